// File: design/mlr_pkg.sv
// Package for the message log ring: store geometry, request codes and the
// beat and status structs shared by the ring modules. No dependencies.
`default_nettype none
package mlr_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = PTR_W + 1;

  localparam logic [7:0] SPACE_SLACK = 8'd3;
  localparam logic [7:0] TERMINATOR  = 8'd0;

  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_BYTE   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] msg_len;
    logic [7:0] data_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       end_of_message;
    logic       empty_res;
  } out_beat_t;

  typedef struct packed {
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_next;
    logic             empty;
    logic             evict;
  } ptr_stat_t;

endpackage
`default_nettype wire

// File: design/mlr_mem.sv
// Byte store of the message log ring: one write port, one registered read port.
// Depends on mlr_pkg for the depth and pointer width.
`default_nettype none
module mlr_mem (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [mlr_pkg::PTR_W-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic [mlr_pkg::PTR_W-1:0] raddr,
  output logic      [7:0]               rdata_r
);
  import mlr_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/mlr_ptr_alu.sv
// Pointer unit of the message log ring: wrapped increments, empty test and the
// free-space compare that drives eviction. Depends on mlr_pkg.
`default_nettype none
module mlr_ptr_alu (
  input  wire logic [mlr_pkg::PTR_W-1:0] wr,
  input  wire logic [mlr_pkg::PTR_W-1:0] rd,
  input  wire logic [7:0]               len,
  output mlr_pkg::ptr_stat_t            stat
);
  import mlr_pkg::*;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(STORE_DEPTH - 1);

  logic [CNT_W-1:0] free_cnt;
  logic [CNT_W-1:0] need_cnt;

  always_comb begin
    if (wr == rd) begin
      free_cnt = CNT_W'(STORE_DEPTH);
    end else if (wr > rd) begin
      free_cnt = CNT_W'(STORE_DEPTH) - {1'b0, wr} + {1'b0, rd};
    end else begin
      free_cnt = {1'b0, rd} - {1'b0, wr};
    end
    need_cnt = CNT_W'(len) + CNT_W'(SPACE_SLACK);

    stat.wr_next = (wr == LAST) ? '0 : wr + 1'b1;
    stat.rd_next = (rd == LAST) ? '0 : rd + 1'b1;
    stat.empty   = (wr == rd);
    stat.evict   = (free_cnt < need_cnt);
  end

endmodule
`default_nettype wire

// File: design/message_log_ring_overwrite_oldest.sv
// Message log ring with oldest-message overwrite: top level, sequencer and
// result register. Depends on mlr_pkg, mlr_mem and mlr_ptr_alu.
// Sequencing: a message byte is written from ST_IDLE; the byte that closes the
// message is followed by ST_TERM, which writes the terminator. A read passes
// through ST_RD and strobes its result from there; an empty read strobes it
// in the cycle after the beat. A begin passes through ST_FREE and, while space
// is short, evicts the oldest message byte by byte via ST_EVCHK and ST_EVWAIT.
// Reset: a clearing pass zeroes all STORE_DEPTH store entries, busy held high.
// Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none
module message_log_ring_overwrite_oldest (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire mlr_pkg::in_beat_t in_beat,
  output logic                   busy,
  output logic                   out_valid,
  output mlr_pkg::out_beat_t     out_beat
);
  import mlr_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,    // sweep zeroes through the store after reset
    ST_IDLE,     // take a beat
    ST_FREE,     // test free space against the begun length
    ST_EVCHK,    // inspect one byte of the oldest message
    ST_EVWAIT,   // let the read port catch up with the advanced read pointer
    ST_RD,       // read data is back, strobe the result
    ST_TERM      // write the terminator after the last message byte
  } state_t;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(STORE_DEPTH - 1);

  state_t           state_r,  state_nxt;
  logic [PTR_W-1:0] wr_r,     wr_nxt;
  logic [PTR_W-1:0] rd_r,     rd_nxt;
  logic [PTR_W-1:0] clr_r,    clr_nxt;
  logic [7:0]       bl_r,     bl_nxt;
  logic [7:0]       len_r,    len_nxt;
  logic             open_r,   open_nxt;
  logic             oval_r,   oval_nxt;
  out_beat_t        obeat_r,  obeat_nxt;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;
  ptr_stat_t        ps;

  // The read port always follows the read pointer, so the byte under it is
  // available in the cycle after the pointer settles.
  mlr_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (rd_r),
    .rdata_r (mem_rdata)
  );

  mlr_ptr_alu u_alu (
    .wr   (wr_r),
    .rd   (rd_r),
    .len  (len_r),
    .stat (ps)
  );

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    clr_nxt   = clr_r;
    bl_nxt    = bl_r;
    len_nxt   = len_r;
    open_nxt  = open_r;
    oval_nxt  = 1'b0;
    obeat_nxt = obeat_r;
    mem_we    = 1'b0;
    mem_waddr = wr_r;
    mem_wdata = TERMINATOR;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          case (in_beat.req_type)
            REQ_BEGIN: begin
              // drop a begin while a message is still open
              if (!open_r) begin
                len_nxt   = in_beat.msg_len;
                state_nxt = ST_FREE;
              end
            end
            REQ_BYTE: begin
              if (open_r) begin
                mem_we    = 1'b1;
                mem_wdata = in_beat.data_in;
                wr_nxt    = ps.wr_next;
                bl_nxt    = bl_r - 1'b1;
                if (bl_r == 8'd1) begin
                  state_nxt = ST_TERM;
                end
              end
            end
            REQ_READ: begin
              if (ps.empty) begin
                oval_nxt  = 1'b1;
                obeat_nxt = '{data_out: TERMINATOR, end_of_message: 1'b0,
                              empty_res: 1'b1};
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FREE: begin
        if (ps.evict) begin
          state_nxt = ST_EVCHK;
        end else if (len_r == 8'd0) begin
          // zero-length message: store a lone terminator, leave nothing open
          mem_we    = 1'b1;
          wr_nxt    = ps.wr_next;
          state_nxt = ST_IDLE;
        end else begin
          bl_nxt    = len_r;
          open_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_EVCHK: begin
        if (ps.empty) begin
          // scan caught up with the write pointer: store is now empty
          state_nxt = ST_FREE;
        end else if (mem_rdata != TERMINATOR) begin
          mem_we    = 1'b1;
          mem_waddr = rd_r;
          rd_nxt    = ps.rd_next;
          state_nxt = ST_EVWAIT;
        end else begin
          // step past the terminator and recheck free space
          rd_nxt    = ps.rd_next;
          state_nxt = ST_FREE;
        end
      end

      ST_EVWAIT: begin
        state_nxt = ST_EVCHK;
      end

      ST_RD: begin
        oval_nxt  = 1'b1;
        obeat_nxt = '{data_out: mem_rdata,
                      end_of_message: (mem_rdata == TERMINATOR),
                      empty_res: 1'b0};
        rd_nxt    = ps.rd_next;
        state_nxt = ST_IDLE;
      end

      ST_TERM: begin
        mem_we    = 1'b1;
        wr_nxt    = ps.wr_next;
        open_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      wr_r    <= '0;
      rd_r    <= '0;
      clr_r   <= '0;
      bl_r    <= '0;
      open_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      clr_r   <= clr_nxt;
      bl_r    <= bl_nxt;
      open_r  <= open_nxt;
      oval_r  <= oval_nxt;
    end
    len_r   <= len_nxt;
    obeat_r <= obeat_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = oval_r;
  assign out_beat  = obeat_r;

endmodule
`default_nettype wire

// File: design/mlr_checker.sv
// Port-level checker for the message log ring and its bind to the top level.
// Depends on mlr_pkg and on message_log_ring_overwrite_oldest.
`default_nettype none
module mlr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire mlr_pkg::in_beat_t  in_beat,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire mlr_pkg::out_beat_t out_beat
);
  import mlr_pkg::*;

  logic read_beat;
  assign read_beat = start && !busy && (in_beat.req_type == REQ_READ);

  // a result may only follow a read beat, directly or after the ST_RD step
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(read_beat) || $past(read_beat, 2)))
    else $error("result without a preceding read beat");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.empty_res |->
      (out_beat.data_out == TERMINATOR) && !out_beat.end_of_message)
    else $error("empty result carries data");

  a_eom_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat.empty_res |->
      (out_beat.end_of_message == (out_beat.data_out == TERMINATOR)))
    else $error("end_of_message disagrees with data");

  // clearing pass holds the block busy right after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy && !out_valid)
    else $error("block not busy after reset");

endmodule

bind message_log_ring_overwrite_oldest mlr_checker u_mlr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_beat   (in_beat),
  .busy      (busy),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);
`default_nettype wire
